// ===== hw/rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared types and helpers of the double-ended queue unit
// Request and response layouts, operation and error codes, controller states
// and the ring pointer arithmetic used by the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int CAPACITY = 16;
   localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W    = COUNT_W + 1;
   localparam int WORD_W   = 64;

   typedef enum logic [2:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_REVERSE    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } error_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [WORD_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] front_value;
      logic [WORD_W-1:0] back_value;
      logic [4:0]        entry_count;
      logic              is_empty;
      logic [1:0]        error_code;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic read;
      logic load;
   } cmd_type;

   // Slot that lies a given number of places after a slot, wrapping at the capacity.
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0]   slot,
                                                 input logic [COUNT_W-1:0] step);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(slot) + SUM_W'(step);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] slot);
      logic [PTR_W-1:0] prev;
      if (slot == '0) begin
         prev = PTR_W'(CAPACITY - 1);
      end else begin
         prev = slot - PTR_W'(1);
      end
      return prev;
   endfunction

endpackage

// ===== hw/rtl/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl: sequencing controller of the double-ended queue unit
// Steps each request through update, store read and response load, and
// tracks whether the response register holds an untaken response.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::cmd_type cmd
);

   dq_pkg::state_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         dq_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = dq_pkg::ST_READ;
            end
         end
         dq_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = dq_pkg::ST_LOAD;
         end
         dq_pkg::ST_LOAD: begin
            // The response register may only be overwritten once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = dq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// dq_datapath: ring store, pointers and response register
// Applies one operation per request to the head pointer, count and direction
// bit, reads the first and last slots and builds the response.
// ----------------------------------------------------------------------------
module dq_datapath (
   input  logic            clock,
   input  logic            reset,
   input  dq_pkg::cmd_type cmd,
   input  dq_pkg::req_type req_data,
   output dq_pkg::rsp_type rsp_data
);

   logic [dq_pkg::WORD_W-1:0]  entry_mem_ff [dq_pkg::CAPACITY];
   logic [dq_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [dq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                       rev_ff, rev_in;
   dq_pkg::error_type          err_ff, err_in;
   logic [dq_pkg::WORD_W-1:0]  first_ff, last_ff;
   dq_pkg::rsp_type            rsp_ff, rsp_in;

   logic                       wr_en;
   logic [dq_pkg::PTR_W-1:0]   wr_addr;
   logic [dq_pkg::PTR_W-1:0]   last_addr;
   logic                       at_end;
   logic                       is_full;
   logic                       is_none;

   assign is_full = (count_ff >= dq_pkg::COUNT_W'(dq_pkg::CAPACITY));
   assign is_none = (count_ff == '0);

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      rev_in  = rev_ff;
      err_in  = dq_pkg::ERR_OK;
      wr_en   = 1'b0;
      wr_addr = dq_pkg::ring_add(head_ff, count_ff);
      at_end  = 1'b0;
      case (dq_pkg::mode_type'(req_data.mode))
         dq_pkg::MODE_PUSH_BACK, dq_pkg::MODE_PUSH_FRONT: begin
            if (is_full) begin
               err_in = dq_pkg::ERR_FULL;
            end else begin
               // The direction bit swaps which end of storage order is the back.
               at_end   = (req_data.mode == dq_pkg::MODE_PUSH_BACK) != rev_ff;
               wr_en    = 1'b1;
               count_in = count_ff + dq_pkg::COUNT_W'(1);
               if (!at_end) begin
                  head_in = dq_pkg::ring_prev(head_ff);
                  wr_addr = dq_pkg::ring_prev(head_ff);
               end
            end
         end
         dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
            if (is_none) begin
               err_in = dq_pkg::ERR_EMPTY;
            end else begin
               at_end   = (req_data.mode == dq_pkg::MODE_POP_BACK) != rev_ff;
               count_in = count_ff - dq_pkg::COUNT_W'(1);
               if (!at_end) begin
                  head_in = dq_pkg::ring_add(head_ff, dq_pkg::COUNT_W'(1));
               end
            end
         end
         dq_pkg::MODE_REVERSE: begin
            if (is_none) begin
               err_in = dq_pkg::ERR_EMPTY;
            end else begin
               rev_in = ~rev_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         entry_mem_ff[wr_addr] <= req_data.item_value;
      end
   end

   assign last_addr = dq_pkg::ring_add(head_ff, count_ff - dq_pkg::COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         first_ff <= entry_mem_ff[head_ff];
         last_ff  <= entry_mem_ff[last_addr];
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.entry_count = 5'(count_ff);
      rsp_in.is_empty    = is_none;
      rsp_in.error_code  = err_ff;
      if (!is_none) begin
         rsp_in.front_value = rev_ff ? last_ff : first_ff;
         rsp_in.back_value  = rev_ff ? first_ff : last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of 64-bit words
// Ring store with head pointer, count and direction bit; every request
// returns the front, back, count, empty flag and an error code.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_ready   dq_pkg::req_type (mode, item_value)
//  rsp      out        rsp_valid/rsp_ready   dq_pkg::rsp_type (front, back, count,
//                                            empty, error)
//
//  A request passes through update of pointers and store write, registered
//  read of the first and last slots, then load of the response register.
//  The single-port-write store with its registered read sets these steps.
//  A new request is taken while an earlier response still waits to be taken;
//  its load then waits until the response register is free.
//  Reset is synchronous and empties the queue; stored words need no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::rsp_type rsp_data
);

   dq_pkg::cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
